// ===== rtl/core/raised_cosine_profile_pd_speed_defines.svh =====
// Assertion macros for the speed profile block checker.
`ifndef RAISED_COSINE_PROFILE_PD_SPEED_DEFINES_SVH
`define RAISED_COSINE_PROFILE_PD_SPEED_DEFINES_SVH
// same-cycle implication
`define RCP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define RCP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/core/rcp_pkg.sv =====
// Package: types, constants and tables of the speed profile block.
`default_nettype none
package rcp_pkg;
    localparam int CFG_IDX_W = 3;
    localparam int PK_W = 26;
    localparam int CORDIC_Z_W = 34;
    localparam int ATAN_IDX_W = 5;
    localparam int ATAN_COUNT = 24;
    localparam longint PI_Q = 205887;
    localparam longint HALF_PI_Q = 102944;
    localparam longint TWO_PI_Q = 411775;
    localparam longint CORDIC_K_Q30 = 652032875;

    localparam logic [31:0] ATAN_Q30 [ATAN_COUNT] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
        32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
        32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_DISTANCE = 3'd0,
        REG_NOMINAL_SPEED   = 3'd1,
        REG_SPEED_CEILING   = 3'd2,
        REG_SPEED_FLOOR     = 3'd3,
        REG_GAIN_P          = 3'd4,
        REG_GAIN_D          = 3'd5,
        REG_START_POSITION  = 3'd6,
        REG_TICK_PERIOD     = 3'd7
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_T_GO, ST_T_WAIT, ST_Q_MUL, ST_Q_GO, ST_Q_WAIT, ST_M_GO, ST_M_WAIT,
        ST_C_GO, ST_C_WAIT, ST_FF, ST_REF_MUL, ST_REF_SAT, ST_ERR, ST_PD_P, ST_PD_D,
        ST_SUM, ST_CLAMP, ST_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/rcp_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module rcp_div #(
    parameter int N_W = 42,
    parameter int D_W = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [N_W-1:0]      dividend,
    input  logic [D_W-1:0]      divisor,
    output rcp_pkg::unit_stat_t stat,
    output logic [N_W-1:0]      quotient
);
    import rcp_pkg::*;
    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0] quo_reg;
    logic [D_W-1:0] rem_reg;
    logic [D_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic busy_reg, done_reg;
    logic [D_W:0] trial;
    logic [D_W:0] diff;
    logic take;

    assign trial = {rem_reg, quo_reg[N_W-1]};
    assign diff = trial - {1'b0, dvs_reg};
    assign take = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                quo_reg <= dividend;
                rem_reg <= '0;
                dvs_reg <= divisor;
                cnt_reg <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= take ? diff[D_W-1:0] : trial[D_W-1:0];
                quo_reg <= {quo_reg[N_W-2:0], take};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(N_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

// ===== rtl/core/rcp_cordic.sv =====
// Rotation CORDIC, one iteration per cycle, Q1.15 outputs.
`default_nettype none
module rcp_cordic #(
    parameter int TRIG_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic signed [rcp_pkg::CORDIC_Z_W-1:0] z0,
    input  logic                                  neg,
    output rcp_pkg::unit_stat_t                   stat,
    output logic signed [16:0]                    cos_q,
    output logic signed [16:0]                    sin_q
);
    import rcp_pkg::*;
    localparam int XY_W = TRIG_BITS + 3;
    localparam int CNT_W = $clog2(TRIG_BITS + 1);
    localparam longint X0 = (CORDIC_K_Q30 + (longint'(1) << (29 - TRIG_BITS)))
                            >>> (30 - TRIG_BITS);
    localparam int SH = TRIG_BITS - 15;
    localparam int SHR = SH > 0 ? SH : 0;
    localparam int SHL = SH < 0 ? -SH : 0;
    localparam longint RND = SHR > 0 ? (longint'(1) << (SHR - 1)) : 0;

    logic signed [XY_W-1:0] x_reg, y_reg, x_sh, y_sh;
    logic signed [CORDIC_Z_W-1:0] z_reg, atan_s;
    logic [CNT_W-1:0] cnt_reg;
    logic busy_reg, done_reg, neg_reg;

    function automatic logic signed [16:0] to_q15(input logic signed [XY_W-1:0] v,
                                                  input logic ng);
        logic signed [39:0] w;
        w = ng ? -40'(v) : 40'(v);
        w = ((w + 40'(RND)) >>> SHR) <<< SHL;
        if (w > 40'sd32768)
            return 17'sd32768;
        else if (w < -40'sd32768)
            return -17'sd32768;
        else
            return w[16:0];
    endfunction

    assign atan_s = CORDIC_Z_W'(ATAN_Q30[ATAN_IDX_W'(cnt_reg)]);
    assign x_sh = x_reg >>> cnt_reg;
    assign y_sh = y_reg >>> cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                x_reg <= XY_W'(X0);
                y_reg <= '0;
                z_reg <= z0;
                neg_reg <= neg;
                cnt_reg <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (z_reg >= 0) begin
                    x_reg <= x_reg - y_sh;
                    y_reg <= y_reg + x_sh;
                    z_reg <= z_reg - atan_s;
                end else begin
                    x_reg <= x_reg + y_sh;
                    y_reg <= y_reg - x_sh;
                    z_reg <= z_reg + atan_s;
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(TRIG_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign cos_q = to_q15(x_reg, neg_reg);
    assign sin_q = to_q15(y_reg, neg_reg);
endmodule
`default_nettype wire

// ===== rtl/core/raised_cosine_profile_pd_speed.sv =====
// Top level: raised-cosine speed profile with PD position feedback.
//  channel  dir  handshake          payload
//  s_       in   s_valid/s_ready    s_encoder_position[31:0]
//  m_       out  m_valid/m_ready    m_speed_command[15:0]
//  cfg_     in   cfg_wr_en          cfg_index[2:0], cfg_data[31:0]
// Each tick makes two passes through the bit-serial divider, runs a 13-step
// compare-and-subtract reduction modulo 2*pi and the CORDIC iterations; a divider
// pass is skipped when its divisor is zero. One item is in flight at a time.
// Reset is synchronous, active low; no clearing pass.
// A result waits in the output register while m_ready is low; the next beat is
// taken meanwhile, and its result waits until that register frees.
`default_nettype none
module raised_cosine_profile_pd_speed #(
    parameter int STEP_BITS = 16,
    parameter int TRIG_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [31:0]                 s_encoder_position,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [15:0]                 m_speed_command,
    input  logic                               cfg_wr_en,
    input  logic [rcp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                        cfg_data
);
    import rcp_pkg::*;
    localparam int N_W = PK_W + STEP_BITS;
    localparam int D_W = 32;
    localparam logic [3:0] MOD_K_TOP = 4'd12;

    state_t state_reg, state_next;

    logic [30:0] dist_reg;
    logic [14:0] speed_reg;
    logic signed [15:0] ceil_reg, floor_reg;
    logic [15:0] gp_reg, gd_reg;
    logic signed [31:0] start_reg;
    logic [7:0] period_reg;

    logic [STEP_BITS-1:0] n_reg;
    logic signed [31:0] last_err_reg;

    logic signed [31:0] meas_reg;
    logic [31:0] tdur_reg;
    logic [30:0] ph_reg;
    logic [30:0] mod_reg;
    logic [3:0] mod_k_reg;
    logic signed [19:0] ang_reg;
    logic neg_reg;
    logic signed [16:0] cos_reg, sin_reg;
    logic signed [16:0] ff_reg;
    logic signed [31:0] ref_reg, err_reg;
    logic signed [60:0] prod_reg, acc_reg;
    logic signed [43:0] pd_reg;
    logic signed [15:0] cmd_reg;
    logic m_valid_reg;
    logic signed [15:0] m_cmd_reg;

    logic div_start, cordic_start;
    logic [N_W-1:0] div_dividend, div_quo;
    logic [D_W-1:0] div_divisor;
    unit_stat_t div_stat, cordic_stat;
    logic signed [16:0] cordic_cos, cordic_sin;

    logic signed [26:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [60:0] prod_next;
    logic [PK_W-1:0] pk;
    logic signed [16:0] h_wide;
    logic signed [15:0] h;
    logic [30:0] mod_sub, mod_step;
    logic signed [19:0] a0, a1, a_fold;
    logic fold_neg;
    logic signed [60:0] ff_full;
    logic signed [49:0] ref_sum, ref_tr;
    logic signed [51:0] err_diff, pd_sum, pd_full;
    logic signed [44:0] cmd_sum, cmd_hi;

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        if (v > 52'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -52'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    rcp_div #(.N_W(N_W), .D_W(D_W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_dividend),
        .divisor(div_divisor), .stat(div_stat), .quotient(div_quo)
    );

    rcp_cordic #(.TRIG_BITS(TRIG_BITS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cordic_start), .z0({ang_reg, 14'b0}),
        .neg(neg_reg), .stat(cordic_stat), .cos_q(cordic_cos), .sin_q(cordic_sin)
    );

    assign pk = PK_W'(period_reg * 18'd205887);
    assign h_wide = (17'(ceil_reg) + 17'(ceil_reg < 0)) >>> 1;
    assign h = h_wide[15:0];

    // modulo 2*pi: subtract 2*pi << k for k = 12 down to 0
    assign mod_sub = {12'b0, 19'(TWO_PI_Q)} << mod_k_reg;
    assign mod_step = (mod_reg >= mod_sub) ? mod_reg - mod_sub : mod_reg;

    // reduce to [-pi, pi] then fold into [-pi/2, pi/2]
    assign a0 = 20'(mod_step[18:0]);
    assign a1 = (a0 > 20'(PI_Q)) ? a0 - 20'(TWO_PI_Q) : a0;
    always_comb begin
        fold_neg = 1'b0;
        a_fold = a1;
        if (a1 > 20'(HALF_PI_Q)) begin
            a_fold = a1 - 20'(PI_Q);
            fold_neg = 1'b1;
        end else if (a1 < -20'(HALF_PI_Q)) begin
            a_fold = a1 + 20'(PI_Q);
            fold_neg = 1'b1;
        end
    end

    assign ff_full = (prod_reg + ((prod_reg < 0) ? 61'sd32767 : 61'sd0)) >>> 15;
    assign ref_sum = {{2{start_reg[31]}}, start_reg, 16'b0} + prod_reg[49:0];
    assign ref_tr = (ref_sum + ((ref_sum < 0) ? 50'sd65535 : 50'sd0)) >>> 16;
    assign err_diff = 52'(ref_reg) - 52'(meas_reg);
    assign pd_sum = acc_reg[51:0] + prod_reg[51:0];
    assign pd_full = (pd_sum + ((pd_sum < 0) ? 52'sd255 : 52'sd0)) >>> 8;
    assign cmd_sum = 45'(pd_reg) + 45'(ff_reg);
    assign cmd_hi = (cmd_sum > 45'(ceil_reg)) ? 45'(ceil_reg) : cmd_sum;
    assign prod_next = mul_a * mul_b;

    always_comb begin
        state_next = state_reg;
        div_start = 1'b0;
        cordic_start = 1'b0;
        div_dividend = N_W'(dist_reg);
        div_divisor = D_W'(speed_reg);
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_T_GO;
            ST_T_GO: begin
                if (speed_reg == '0) begin
                    state_next = ST_Q_MUL;
                end else begin
                    div_start = 1'b1;
                    state_next = ST_T_WAIT;
                end
            end
            ST_T_WAIT: if (div_stat.done) state_next = ST_Q_MUL;
            ST_Q_MUL: begin
                mul_a = 27'(pk);
                mul_b = 34'(n_reg);
                state_next = ST_Q_GO;
            end
            ST_Q_GO: begin
                div_dividend = prod_reg[N_W-1:0];
                div_divisor = tdur_reg;
                if (tdur_reg == '0) begin
                    state_next = ST_M_GO;
                end else begin
                    div_start = 1'b1;
                    state_next = ST_Q_WAIT;
                end
            end
            ST_Q_WAIT: if (div_stat.done) state_next = ST_M_GO;
            ST_M_GO: state_next = ST_M_WAIT;
            ST_M_WAIT: if (mod_k_reg == '0) state_next = ST_C_GO;
            ST_C_GO: begin
                cordic_start = 1'b1;
                state_next = ST_C_WAIT;
            end
            ST_C_WAIT: if (cordic_stat.done) state_next = ST_FF;
            ST_FF: begin
                mul_a = 27'(h);
                mul_b = 34'(cos_reg) + 34'sd32768;
                state_next = ST_REF_MUL;
            end
            ST_REF_MUL: begin
                mul_a = 27'(h);
                mul_b = {{16{sin_reg[16]}}, sin_reg, 1'b0} + {3'b0, ph_reg};
                state_next = ST_REF_SAT;
            end
            ST_REF_SAT: state_next = ST_ERR;
            ST_ERR: state_next = ST_PD_P;
            ST_PD_P: begin
                mul_a = 27'(gp_reg);
                mul_b = 34'(err_reg);
                state_next = ST_PD_D;
            end
            ST_PD_D: begin
                mul_a = 27'(gd_reg);
                mul_b = 34'(err_reg) - 34'(last_err_reg);
                state_next = ST_SUM;
            end
            ST_SUM: state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_OUT;
            ST_OUT: if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_reg <= '0;
            speed_reg <= 15'd1;
            ceil_reg <= '0;
            floor_reg <= '0;
            gp_reg <= '0;
            gd_reg <= '0;
            start_reg <= '0;
            period_reg <= 8'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_TARGET_DISTANCE: dist_reg <= cfg_data[30:0];
                REG_NOMINAL_SPEED:   speed_reg <= cfg_data[14:0];
                REG_SPEED_CEILING:   ceil_reg <= cfg_data[15:0];
                REG_SPEED_FLOOR:     floor_reg <= cfg_data[15:0];
                REG_GAIN_P:          gp_reg <= cfg_data[15:0];
                REG_GAIN_D:          gd_reg <= cfg_data[15:0];
                REG_START_POSITION:  start_reg <= cfg_data;
                REG_TICK_PERIOD:     period_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg <= '0;
            last_err_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
                m_cmd_reg <= cmd_reg;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_SUM) begin
                last_err_reg <= err_reg;
                if (n_reg != '1)
                    n_reg <= n_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        unique case (state_reg)
            ST_IDLE: meas_reg <= s_encoder_position;
            ST_T_GO: tdur_reg <= '0;
            ST_T_WAIT: tdur_reg <= {div_quo[30:0], 1'b0};
            ST_Q_GO: ph_reg <= '0;
            ST_Q_WAIT: ph_reg <= (div_quo[N_W-1:31] != '0) ? 31'h7FFFFFFF : div_quo[30:0];
            ST_M_GO: begin
                mod_reg <= ph_reg;
                mod_k_reg <= MOD_K_TOP;
            end
            ST_M_WAIT: begin
                mod_reg <= mod_step;
                mod_k_reg <= mod_k_reg - 1'b1;
                ang_reg <= a_fold;
                neg_reg <= fold_neg;
            end
            ST_C_WAIT: begin
                cos_reg <= cordic_cos;
                sin_reg <= cordic_sin;
            end
            ST_REF_MUL: ff_reg <= ff_full[16:0];
            ST_REF_SAT: ref_reg <= sat32(52'(ref_tr));
            ST_ERR: err_reg <= sat32(err_diff);
            ST_PD_D: acc_reg <= prod_reg;
            ST_SUM: pd_reg <= pd_full[43:0];
            ST_CLAMP: cmd_reg <= (cmd_hi < 45'(floor_reg)) ? floor_reg : cmd_hi[15:0];
            default: ;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_speed_command = m_cmd_reg;
endmodule
`default_nettype wire

// ===== rtl/core/rcp_checker.sv =====
// Port-level checker for the speed profile block, with its bind.
`default_nettype none
`include "raised_cosine_profile_pd_speed_defines.svh"
module rcp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic signed [31:0]            s_encoder_position,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [15:0]            m_speed_command,
    input logic                          cfg_wr_en,
    input logic [rcp_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [31:0]                   cfg_data
);
    logic unused_ok;
    assign unused_ok = ^{s_encoder_position, cfg_wr_en, cfg_index, cfg_data};

    `RCP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_speed_command), "result beat dropped or changed while stalled")
    `RCP_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "input taken again before tick finished")
    `RCP_ASSERT_NEXT(a_no_instant_result, aclk, aresetn, s_valid && s_ready, !$rose(m_valid), "result appeared right after input beat")
endmodule

bind raised_cosine_profile_pd_speed rcp_checker u_rcp_checker (.*);
`default_nettype wire

// ===== tb/sv/raised_cosine_profile_pd_speed_test.sv =====
// Testbench for the raised-cosine speed profile block with PD position feedback.
`timescale 1ns / 1ps
`default_nettype none

class speed_profile_board;
    longint unsigned dist_v, speed, period, gp, gd;
    longint ceil_v, floor_v, start_v;
    longint unsigned step_n;
    longint last_err;
    logic signed [15:0] cmd_q[$];
    int errors;

    function new();
        dist_v = 0; speed = 1; period = 1; gp = 0; gd = 0;
        ceil_v = 0; floor_v = 0; start_v = 0;
        step_n = 0; last_err = 0; errors = 0;
    endfunction

    function void set_reg(rcp_pkg::cfg_idx_t idx, logic [31:0] d);
        case (idx)
            rcp_pkg::REG_TARGET_DISTANCE: dist_v = d[30:0];
            rcp_pkg::REG_NOMINAL_SPEED:   speed = d[14:0];
            rcp_pkg::REG_SPEED_CEILING:   ceil_v = longint'($signed(d[15:0]));
            rcp_pkg::REG_SPEED_FLOOR:     floor_v = longint'($signed(d[15:0]));
            rcp_pkg::REG_GAIN_P:          gp = d[15:0];
            rcp_pkg::REG_GAIN_D:          gd = d[15:0];
            rcp_pkg::REG_START_POSITION:  start_v = longint'($signed(d));
            rcp_pkg::REG_TICK_PERIOD:     period = d[7:0];
            default: ;
        endcase
    endfunction

    function longint to_q15(longint v);
        longint r;
        r = (v + 1) >>> 1;
        if (r < -32768) r = -32768;
        if (r > 32768) r = 32768;
        return r;
    endfunction

    function longint sat32(longint v);
        if (v < -64'sd2147483648) return -64'sd2147483648;
        if (v > 64'sd2147483647) return 64'sd2147483647;
        return v;
    endfunction

    function void note_position(logic signed [31:0] enc);
        longint unsigned tdur, q;
        longint ph, a, x, y, z, t, c, s, h, ff, rf, err, pd, cmd;
        bit neg;
        tdur = (speed != 0) ? (dist_v / speed) * 2 : 0;
        ph = 0;
        if (tdur != 0) begin
            q = (64'd205887 * period * step_n) / tdur;
            ph = (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
        end
        a = ph % rcp_pkg::TWO_PI_Q;
        neg = 0;
        if (a > rcp_pkg::PI_Q) a = a - rcp_pkg::TWO_PI_Q;
        if (a > rcp_pkg::HALF_PI_Q) begin
            a = a - rcp_pkg::PI_Q; neg = 1;
        end else if (a < -rcp_pkg::HALF_PI_Q) begin
            a = a + rcp_pkg::PI_Q; neg = 1;
        end
        z = a * 16384;
        x = (rcp_pkg::CORDIC_K_Q30 + (64'sd1 << 13)) >>> 14;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            t = x;
            if (z >= 0) begin
                x = x - (y >>> i); y = y + (t >>> i);
                z = z - longint'(rcp_pkg::ATAN_Q30[i]);
            end else begin
                x = x + (y >>> i); y = y - (t >>> i);
                z = z + longint'(rcp_pkg::ATAN_Q30[i]);
            end
        end
        c = to_q15(neg ? -x : x);
        s = to_q15(neg ? -y : y);
        h = ceil_v / 2;
        ff = (h * (c + 32768)) / 32768;
        rf = sat32((start_v * 65536 + h * (s * 2 + ph)) / 65536);
        err = sat32(rf - longint'(enc));
        pd = (longint'(gp) * err + longint'(gd) * (err - last_err)) / 256;
        last_err = err;
        cmd = ff + pd;
        if (cmd > ceil_v) cmd = ceil_v;
        if (cmd < floor_v) cmd = floor_v;
        if (step_n < 65535) step_n++;
        cmd_q.push_back(cmd[15:0]);
    endfunction

    function void check_command(logic signed [15:0] got);
        logic signed [15:0] want;
        if (cmd_q.size() == 0) begin
            $error("speed_command: unexpected beat, actual %0d", got);
            errors++;
            return;
        end
        want = cmd_q.pop_front();
        if (got !== want) begin
            $error("speed_command: expected %0d actual %0d", want, got);
            errors++;
        end
    endfunction
endclass

module raised_cosine_profile_pd_speed_test;
    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready, cfg_wr_en;
    logic signed [31:0] s_encoder_position;
    logic signed [15:0] m_speed_command;
    logic [rcp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    speed_profile_board board = new();
    int send_idle_pct, recv_idle_pct;
    bit hold_req;

    raised_cosine_profile_pd_speed uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_encoder_position(s_encoder_position),
        .m_valid(m_valid), .m_ready(m_ready), .m_speed_command(m_speed_command),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("FAIL raised_cosine_profile_pd_speed");
        $finish;
    end

    always @(posedge aclk)
        if (aresetn && m_valid && m_ready) board.check_command(m_speed_command);

    // receiver: random stalls, or a long hold-off on request
    initial begin
        int hold_n;
        m_ready = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 0;
                m_ready <= 0;
                for (hold_n = 0; hold_n < 800; hold_n++) @(negedge aclk);
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic load_profile(logic [31:0] v[8]);
        for (int i = 0; i < 8; i++) begin
            cfg_wr_en <= 1;
            cfg_index <= rcp_pkg::cfg_idx_t'(i);
            cfg_data <= v[i];
            @(negedge aclk);
            board.set_reg(rcp_pkg::cfg_idx_t'(i), v[i]);
        end
        cfg_wr_en <= 0;
    endtask

    task automatic send_position(logic signed [31:0] enc);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid <= 1;
        s_encoder_position <= enc;
        do @(posedge aclk); while (!s_ready);
        board.note_position(enc);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (board.cmd_q.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    function automatic logic signed [31:0] pick_position(longint base);
        if ($urandom_range(3) == 0) return $urandom;
        return 32'(base + $signed($urandom_range(4000)) - 2000);
    endfunction

    initial begin
        logic [31:0] cfg[8];
        logic signed [31:0] dir_pos[6];
        aresetn = 0; s_valid = 0; cfg_wr_en = 0;
        cfg_index = rcp_pkg::REG_TARGET_DISTANCE; cfg_data = 0; s_encoder_position = 0;
        hold_req = 0; send_idle_pct = 0; recv_idle_pct = 0;
        repeat (4) @(negedge aclk);
        aresetn = 1;
        dir_pos = '{32'sh0, -32'sd1, 32'sh80000000, 32'sh7FFFFFFF, 32'sh55555555,
                    32'shAAAAAAAA};
        // zero duration, extreme gains and clamps
        cfg = '{32'd0, 32'd1, 32'h7FFF, 32'hFFFF8000, 32'hFFFF, 32'hFFFF,
                32'h80000000, 32'd255};
        load_profile(cfg);
        foreach (dir_pos[i]) send_position(dir_pos[i]);
        drain();
        // shortest nonzero duration, longest period
        cfg = '{32'd1, 32'd1, 32'hFFFF8000, 32'h7FFF, 32'd256, 32'd0,
                32'h7FFFFFFF, 32'd255};
        load_profile(cfg);
        foreach (dir_pos[i]) send_position(dir_pos[i]);
        drain();
        // crossed clamps, longest distance at the highest nominal speed
        cfg = '{32'h7FFFFFFF, 32'h7FFF, 32'd100, 32'd200, 32'd0, 32'd1000,
                32'd0, 32'd1};
        load_profile(cfg);
        foreach (dir_pos[i]) send_position(dir_pos[i]);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            send_idle_pct = (ph < 3) ? 8 : (ph < 6) ? 49 : 0;
            recv_idle_pct = (ph < 3) ? 49 : (ph < 6) ? 8 : 0;
            cfg[0] = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom & 32'h7FFFFFFF;
            cfg[0] = ($urandom_range(1)) ? $urandom_range(200000) : cfg[0];
            cfg[1] = $urandom_range(1, 32767);
            if ($urandom_range(1)) cfg[1] = $urandom_range(1, 20);
            cfg[2] = $urandom; cfg[3] = $urandom;
            if ($urandom_range(3) != 0) begin
                cfg[2] = $urandom_range(32767);
                cfg[3] = -$signed($urandom_range(32768));
            end
            cfg[4] = $urandom_range(1) ? $urandom_range(512) : $urandom_range(65535);
            cfg[5] = $urandom_range(1) ? $urandom_range(512) : $urandom_range(65535);
            cfg[6] = $urandom;
            cfg[7] = $urandom_range(1, 255);
            load_profile(cfg);
            for (int k = 0; k < 100; k++) begin
                if (ph == 1 && k == 20) hold_req = 1;
                if (ph == 4 && k == 50) drain();
                send_position(pick_position(longint'($signed(cfg[6]))));
            end
            drain();
        end

        if (board.errors == 0 && board.cmd_q.size() == 0)
            $display("PASS raised_cosine_profile_pd_speed");
        else
            $display("FAIL raised_cosine_profile_pd_speed");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/rcp_pkg.sv
rtl/core/rcp_div.sv
rtl/core/rcp_cordic.sv
rtl/core/raised_cosine_profile_pd_speed.sv
rtl/core/rcp_checker.sv
tb/sv/raised_cosine_profile_pd_speed_test.sv
